// ----- sv/plt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Probing lookup table package
// Shared sizes, codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package plt_pkg;

  localparam int ENTRIES = 512;
  localparam int IDX_W   = $clog2(ENTRIES);

  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 32;
  localparam int COUNT_W  = 32;

  localparam int IN_DATA_W  = KEY_W + HANDLE_W;
  localparam int OUT_DATA_W = HANDLE_W + 2 * COUNT_W;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  typedef logic [1:0] status_t;
  localparam status_t ST_BYPASS   = 2'd0;
  localparam status_t ST_FOUND    = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;
  localparam status_t ST_FILLED   = 2'd3;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_FILL   = 1'b1;

  localparam logic [CFG_AW-1:0] REG_ENABLE_ADDR = 3'd0;

  typedef struct packed {
    logic                used;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic clr;     // write one cleared entry of the store
    logic load;    // capture an accepted transaction
    logic rd;      // read the entry at the probe index
    logic eval;    // evaluate the read entry, advance the probe
    logic finish;  // commit fill, update counters, load output register
  } plt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic bypass;
    logic stop;
    logic out_free;
  } plt_sts_t;

endpackage

// ----- sv/plt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Probing lookup table controller
// Sequences clearing, probe reads and compares, and result hand-off.
// ----------------------------------------------------------------------------
module plt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  plt_pkg::plt_sts_t sts,
  output plt_pkg::plt_cmd_t cmd
);
  import plt_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CMP,
    S_DONE
  } state_t;

  state_t state_r;
  logic   rdy_r;

  assign in_tready = rdy_r;

  always_comb begin
    cmd        = '0;
    cmd.clr    = (state_r == S_CLEAR);
    cmd.load   = (state_r == S_IDLE) && rdy_r && in_tvalid;
    cmd.rd     = (state_r == S_READ) && !sts.bypass;
    cmd.eval   = (state_r == S_CMP);
    cmd.finish = (state_r == S_DONE) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      rdy_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          if (sts.clr_last) begin
            state_r <= S_IDLE;
            rdy_r   <= 1'b1;
          end
        end
        S_IDLE: begin
          if (rdy_r && in_tvalid) begin
            state_r <= S_READ;
            rdy_r   <= 1'b0;
          end
        end
        S_READ: begin
          state_r <= sts.bypass ? S_DONE : S_CMP;
        end
        S_CMP: begin
          state_r <= sts.stop ? S_DONE : S_READ;
        end
        S_DONE: begin
          if (sts.out_free) begin
            state_r <= S_IDLE;
            rdy_r   <= 1'b1;
          end
        end
        default: begin
          state_r <= S_CLEAR;
          rdy_r   <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- sv/plt_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Probing lookup table datapath
// Entry store, probe index, counters and the output register.
// ----------------------------------------------------------------------------
module plt_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               enable,
  input  logic                               in_command,
  input  logic [plt_pkg::IN_DATA_W-1:0]      in_data,
  input  plt_pkg::plt_cmd_t                  cmd,
  output plt_pkg::plt_sts_t                  sts,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [plt_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [1:0]                         out_tuser
);
  import plt_pkg::*;

  entry_t mem [ENTRIES];
  entry_t rd_q;

  logic                cmd_r;
  logic [KEY_W-1:0]    key_r;
  logic [HANDLE_W-1:0] hdl_r;
  logic                byp_r;
  logic [IDX_W-1:0]    idx_r;
  logic [IDX_W-1:0]    home_r;
  logic [IDX_W-1:0]    cnt_r;
  logic                hit_r;
  logic [IDX_W-1:0]    clr_idx_r;

  logic [COUNT_W-1:0]  hit_cnt_r, hit_cnt_nxt;
  logic [COUNT_W-1:0]  miss_cnt_r, miss_cnt_nxt;

  logic                out_valid_r;
  status_t             out_status_r, out_status_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic [COUNT_W-1:0]  out_hit_r;
  logic [COUNT_W-1:0]  out_miss_r;

  logic [KEY_W-1:0]    in_key;
  logic [HANDLE_W-1:0] in_handle;
  logic [IDX_W-1:0]    idx_next;
  logic                key_match;
  logic                exhausted;
  logic                do_fill;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  entry_t              wr_data;

  assign in_key    = in_data[KEY_W-1:0];
  assign in_handle = in_data[IN_DATA_W-1:KEY_W];

  assign idx_next  = (idx_r == IDX_W'(ENTRIES - 1)) ? '0 : idx_r + 1'b1;
  assign key_match = rd_q.used && (rd_q.key == key_r);
  assign exhausted = (cnt_r == IDX_W'(ENTRIES - 1));
  assign do_fill   = !byp_r && (cmd_r == CMD_FILL);

  assign sts.clr_last = (clr_idx_r == IDX_W'(ENTRIES - 1));
  assign sts.bypass   = byp_r;
  assign sts.stop     = !rd_q.used || key_match || exhausted;
  assign sts.out_free = !out_valid_r || out_tready;

  // Single write port: clearing sweep or fill commit
  always_comb begin
    wr_en   = cmd.clr || (cmd.finish && do_fill);
    wr_addr = cmd.clr ? clr_idx_r : idx_r;
    wr_data = '0;
    if (!cmd.clr) begin
      wr_data.used   = 1'b1;
      wr_data.key    = key_r;
      wr_data.handle = hdl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_q <= mem[idx_r];
    end
  end

  // Probe state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_command;
      key_r  <= in_key;
      hdl_r  <= in_handle;
      byp_r  <= !enable || (in_key == '0);
      idx_r  <= IDX_W'(in_key % KEY_W'(ENTRIES));
      home_r <= IDX_W'(in_key % KEY_W'(ENTRIES));
      cnt_r  <= '0;
      hit_r  <= 1'b0;
    end else if (cmd.eval) begin
      if (!rd_q.used || key_match) begin
        hit_r <= key_match;
      end else if (exhausted) begin
        hit_r <= 1'b0;
        idx_r <= home_r;
      end else begin
        idx_r <= idx_next;
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Result and counter update
  always_comb begin
    hit_cnt_nxt    = hit_cnt_r;
    miss_cnt_nxt   = miss_cnt_r;
    out_status_nxt = ST_BYPASS;
    out_handle_nxt = '0;
    if (do_fill) begin
      out_status_nxt = ST_FILLED;
      out_handle_nxt = hdl_r;
      if (hdl_r != '0) begin
        hit_cnt_nxt = hit_cnt_r + 1'b1;
      end else begin
        miss_cnt_nxt = miss_cnt_r + 1'b1;
      end
    end else if (!byp_r) begin
      if (hit_r) begin
        out_status_nxt = ST_FOUND;
        out_handle_nxt = rd_q.handle;
        if (rd_q.handle != '0) begin
          hit_cnt_nxt = hit_cnt_r + 1'b1;
        end
      end else begin
        out_status_nxt = ST_NOTFOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_idx_r <= sts.clr_last ? '0 : clr_idx_r + 1'b1;
      end
      if (cmd.finish) begin
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= out_status_nxt;
      out_handle_r <= out_handle_nxt;
      out_hit_r    <= hit_cnt_nxt;
      out_miss_r   <= miss_cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_miss_r, out_hit_r, out_handle_r};

endmodule

// ----- sv/probing_lookup_table_with_negative_cache.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Probing lookup table with negative cache
// Open-addressed, linearly probed table of 64-bit keys with 32-bit handles.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Transaction contents
//  --------+-----------+--------------------------------------------------
//  in_     | slave     | tuser: command; tdata: key, handle
//  out_    | master    | tuser: status; tdata: found_handle, hit, miss
//  cfg_    | APB slave | enable register at byte address 0
//
//  Sequence: a bypassed transaction passes S_READ to S_DONE, which loads
//  its result; an active one alternates a store read (S_READ) and a compare
//  (S_CMP) for each entry probed (1 up to ENTRIES), then reaches S_DONE.
//  Each probe reads the store once, on its single read port, and compares.
//  Reset: after rst_n is released, a clearing sweep writes every entry once
//  (ENTRIES writes, 512 here); in_tready stays low until it completes.
//  Stalls: a new transaction is accepted while a result waits in the output
//  register; its result is held back until out_tready frees that register.
//
module probing_lookup_table_with_negative_cache (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tuser: [0] command
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic                              in_tuser,
  // in_tdata: [63:0] key, [95:64] handle
  input  logic [plt_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tuser: [1:0] status
  output logic [1:0]                        out_tuser,
  // out_tdata: [31:0] found_handle, [63:32] hit_total, [95:64] miss_total
  output logic [plt_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [plt_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [plt_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [plt_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);
  import plt_pkg::*;

  logic     enable_r;
  logic     cfg_wr;
  plt_cmd_t cmd;
  plt_sts_t sts;

  // Configuration: zero-wait APB, one register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr == REG_ENABLE_ADDR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_wr) begin
      enable_r <= cfg_pwdata[0];
    end
  end

  // Read back the register; unmapped addresses return zero
  assign cfg_prdata = (cfg_paddr == REG_ENABLE_ADDR)
                      ? {{(CFG_DW-1){1'b0}}, enable_r} : '0;

  plt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  plt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .enable     (enable_r),
    .in_command (in_tuser),
    .in_data    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- sv/plt_sva.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Probing lookup table port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
module plt_sva (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [1:0]                     out_tuser,
  input logic [plt_pkg::OUT_DATA_W-1:0] out_tdata
);
  import plt_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
                                  && $stable(out_tuser))
    else $error("stalled result changed");

  // One transaction at a time: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready stayed high after accept");

  // Bypassed and missed lookups carry no handle
  a_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_BYPASS || out_tuser == ST_NOTFOUND)
    |-> out_tdata[HANDLE_W-1:0] == '0)
    else $error("handle on bypass or miss");

  // A result that reports no table action leaves counters as the last result did
  a_bypass_counters: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready ##1 out_tvalid && out_tuser == ST_BYPASS
    |-> out_tdata[OUT_DATA_W-1:HANDLE_W] == $past(out_tdata[OUT_DATA_W-1:HANDLE_W])
        || !$past(out_tvalid))
    else $error("counters moved on bypass");

endmodule

bind probing_lookup_table_with_negative_cache plt_sva u_plt_sva (.*);

// ----- verif/tb_probing_lookup_table_with_negative_cache.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Probing lookup table testbench
// Drives lookup and fill transactions through the stream ports and toggles the
// enable register over APB. A scoreboard class keeps its own copy of the
// linearly probed table and the hit/miss counters, predicts the reply for
// every accepted request and checks the replies in order, field by field.
// Both ports idle and stall at random. The run ends with a table that is
// completely full, so home-slot overwrites and full-length probe walks occur.
// ----------------------------------------------------------------------------
module tb_probing_lookup_table_with_negative_cache;
  import plt_pkg::*;

  // Generous ceiling: thousands of transactions could each walk all entries.
  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int          POOL_SIZE   = 128;
  localparam int          RANDOM_REQS = 1500;

  typedef struct {
    status_t             status;
    logic [HANDLE_W-1:0] handle;
    logic [COUNT_W-1:0]  hits;
    logic [COUNT_W-1:0]  misses;
  } reply_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirror of the table plus the queue of replies still owed
  // --------------------------------------------------------------------------
  class lookup_scoreboard;
    logic [KEY_W-1:0]    slot_key[ENTRIES];
    logic [HANDLE_W-1:0] slot_handle[ENTRIES];
    bit                  slot_used[ENTRIES];
    logic [COUNT_W-1:0]  hits;
    logic [COUNT_W-1:0]  misses;
    bit                  enabled;
    reply_t              owed_replies[$];
    int                  failures;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      hits     = '0;
      misses   = '0;
      enabled  = 1'b0;
      failures = 0;
    endfunction

    // Predict the reply of an accepted request and update the mirror.
    function void note_request(logic cmd, logic [KEY_W-1:0] key,
                               logic [HANDLE_W-1:0] handle);
      reply_t          r;
      logic [IDX_W-1:0] home;
      logic [IDX_W-1:0] slot;
      bit              matched;
      bit              stopped;
      r.status = ST_BYPASS;
      r.handle = '0;
      if (enabled && key != '0) begin
        home    = IDX_W'(key % ENTRIES);
        slot    = home;
        matched = 1'b0;
        stopped = 1'b0;
        // Walk forward from home until a free slot or the key itself.
        for (int n = 0; n < ENTRIES && !stopped; n++) begin
          slot = IDX_W'((home + n) % ENTRIES);
          if (!slot_used[slot]) begin
            stopped = 1'b1;
          end else if (slot_key[slot] == key) begin
            matched = 1'b1;
            stopped = 1'b1;
          end
        end
        // Full table, no match: land on the home slot.
        if (!stopped) slot = home;
        if (cmd == CMD_LOOKUP) begin
          if (matched) begin
            r.status = ST_FOUND;
            r.handle = slot_handle[slot];
            if (r.handle != '0) hits = hits + 1'b1;
          end else begin
            r.status = ST_NOTFOUND;
          end
        end else begin
          slot_key[slot]    = key;
          slot_handle[slot] = handle;
          slot_used[slot]   = 1'b1;
          r.status = ST_FILLED;
          r.handle = handle;
          if (handle != '0) hits = hits + 1'b1;
          else misses = misses + 1'b1;
        end
      end
      r.hits   = hits;
      r.misses = misses;
      owed_replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        failures++;
      end
    endfunction

    // Check an accepted reply against the oldest prediction.
    function void check_reply(logic [1:0] status, logic [OUT_DATA_W-1:0] data);
      reply_t want;
      if (owed_replies.size() == 0) begin
        $display("%0t: reply with nothing owed, actual status %h data %h",
                 $time, status, data);
        failures++;
        return;
      end
      want = owed_replies.pop_front();
      compare_field("status", 32'(want.status), 32'(status));
      compare_field("found_handle", want.handle, data[HANDLE_W-1:0]);
      compare_field("hit_total", want.hits, data[HANDLE_W +: COUNT_W]);
      compare_field("miss_total", want.misses, data[HANDLE_W+COUNT_W +: COUNT_W]);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic                  in_tuser = CMD_LOOKUP;  // [0] command
  logic [IN_DATA_W-1:0]  in_tdata = '0;          // [63:0] key, [95:64] handle
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [1:0]            out_tuser;              // [1:0] status
  logic [OUT_DATA_W-1:0] out_tdata;              // [31:0] handle, [63:32] hits, [95:64] misses
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr = '0;
  logic [CFG_DW-1:0]     cfg_pwdata = '0;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  lookup_scoreboard sb = new();
  bit               steady = 1'b0;   // when set, neither side idles
  int unsigned      cycles = 0;
  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  probing_lookup_table_with_negative_cache dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Reply side: stall at random, then take one transaction and check it
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      sb.check_reply(out_tuser, out_tdata);
    end
  end

  // --------------------------------------------------------------------------
  // Request side helpers
  // --------------------------------------------------------------------------
  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    do k = {$urandom, $urandom}; while (k == '0);
    return k;
  endfunction

  // Zero and all-ones handles show up often; the rest is uniform.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r == 2) return '1;
    return $urandom;
  endfunction

  // Mostly pooled keys so lookups hit and fills rewrite; some new, some zero.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 25) return fresh_key();
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Idle a random number of cycles, then hold valid until the transaction
  // is taken. Valid stays high on return; drain_replies drops it.
  task automatic send_request(input logic cmd, input logic [KEY_W-1:0] key,
                              input logic [HANDLE_W-1:0] handle);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {handle, key};
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_request(cmd, key, handle);
  endtask

  task automatic send_random();
    send_request($urandom_range(0, 1) ? CMD_FILL : CMD_LOOKUP, pick_key(), pick_handle());
  endtask

  // Stop sending and wait until every owed reply has come back.
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.owed_replies.size() != 0);
    // Allow the block to settle back to idle.
    repeat (8) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_enable(input logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_ENABLE_ADDR;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.enabled = value[0];
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    // Keys whose home slots are 511 (two of them, plus all ones) and 0.
    logic [KEY_W-1:0] k_a, k_b, k_c, k_d;
    logic [KEY_W-1:0] full_keys[$];
    logic [KEY_W-1:0] k;
    k_a = 64'h0000_0000_0000_01FF;
    k_b = 64'h0000_0001_0000_01FF;
    k_c = 64'hFFFF_FFFF_FFFF_FFFF;
    k_d = 64'h8000_0000_0000_0000;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Disabled after reset: every transaction is bypassed.
    send_request(CMD_LOOKUP, k_a, '0);
    send_request(CMD_FILL, k_a, 32'd5);
    drain_replies();
    write_enable(32'h0000_0001);

    // Directed: zero key, misses, negatives, rewrites, probing around the end.
    send_request(CMD_LOOKUP, '0, '0);
    send_request(CMD_FILL, '0, '1);
    send_request(CMD_LOOKUP, k_a, '0);
    send_request(CMD_FILL, k_a, '1);
    send_request(CMD_LOOKUP, k_a, '0);
    send_request(CMD_FILL, k_b, '0);              // wraps to slot 0
    send_request(CMD_LOOKUP, k_b, '0);            // cached negative
    send_request(CMD_FILL, k_c, 32'd1);           // slot 1
    send_request(CMD_LOOKUP, k_c, '0);
    send_request(CMD_LOOKUP, 64'h8000_0000_0000_01FF, '0);  // walks to slot 2
    send_request(CMD_FILL, k_b, 32'hA5A5_5A5A);   // negative becomes positive
    send_request(CMD_LOOKUP, k_b, '0);
    send_request(CMD_FILL, k_a, '0);              // positive becomes negative
    send_request(CMD_LOOKUP, k_a, '0);
    send_request(CMD_LOOKUP, 64'h1, '0);
    send_request(CMD_FILL, k_d, 32'h8000_0000);   // home 0, lands in slot 2
    send_request(CMD_LOOKUP, k_d, '0);

    // Pool: half clustered around the wrap point, half anywhere.
    foreach (key_pool[i]) begin
      k = fresh_key();
      if (i < POOL_SIZE / 2) begin
        k = k - (k % ENTRIES) + ((500 + $urandom_range(0, 15)) % ENTRIES);
        if (k == '0) k = KEY_W'(ENTRIES);
      end
      key_pool[i] = k;
    end

    // Random traffic with pauses, no-idle stretches and a disabled window.
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if ($urandom_range(0, 63) == 0) steady = ~steady;
      if (i % 300 == 299) drain_replies();
      if (i == RANDOM_REQS / 2) begin
        drain_replies();
        write_enable(32'hFFFF_FFFE);
        repeat (40) send_random();
        drain_replies();
        write_enable(32'hFFFF_FFFF);
      end
      send_random();
    end
    steady = 1'b0;

    // Fill every free slot at its own home so the table ends up full.
    drain_replies();
    for (int s = 0; s < ENTRIES; s++) begin
      if (!sb.slot_used[s]) begin
        do begin
          k = fresh_key();
          k = k - (k % ENTRIES) + s;
        end while (k == '0);
        send_request(CMD_FILL, k, pick_handle());
      end
    end

    // Full table: home overwrites and lookups that walk every entry.
    for (int j = 0; j < 24; j++) begin
      case (j == 0 ? 0 : $urandom_range(0, 3))
        0: begin
          k = fresh_key();
          full_keys.push_back(k);
          send_request(CMD_FILL, k, pick_handle());
        end
        1: send_request(CMD_LOOKUP, fresh_key(), '0);
        2: send_request(CMD_LOOKUP, full_keys[$urandom_range(0, full_keys.size() - 1)], '0);
        default: send_request(CMD_FILL, key_pool[$urandom_range(0, POOL_SIZE - 1)],
                              pick_handle());
      endcase
    end

    // Disable again and check the bypass on a full table.
    drain_replies();
    write_enable(32'h0000_0000);
    repeat (4) send_random();

    drain_replies();
    if (sb.failures == 0 && sb.owed_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/plt_pkg.sv
sv/plt_ctrl.sv
sv/plt_dp.sv
sv/probing_lookup_table_with_negative_cache.sv
sv/plt_sva.sv
verif/tb_probing_lookup_table_with_negative_cache.sv
